>>> rtl/sles_pkg.sv
// Shared types and constants of the status LED event sequencer.
// No dependencies; every file of the block but the tick and frame interfaces refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sles_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ALARM_TRIP_LEVEL   = 3'd0,
    REG_FIRE_DURATION      = 3'd1,
    REG_SETUP_DURATION     = 3'd2,
    REG_RESET_DURATION     = 3'd3,
    REG_CONNECT_DURATION   = 3'd4,
    REG_DISCONNECT_DURATION = 3'd5,
    REG_BLINK_HALF_PERIOD  = 3'd6
  } reg_index_t;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Link state codes; four and above all mean "other"
  localparam logic [2:0] LINK_UNKNOWN = 3'd0;
  localparam logic [2:0] LINK_SETUP   = 3'd1;
  localparam logic [2:0] LINK_RESET   = 3'd2;
  localparam logic [2:0] LINK_RUNNING = 3'd3;

  // Animation kinds, also the reported animation code
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ALARM   = 2'd1,
    KIND_LINK    = 2'd2,
    KIND_CONNECT = 2'd3
  } anim_kind_t;

  // Blink timing
  localparam logic [11:0] FIRE_HALF_MS     = 12'd500;
  localparam logic [11:0] BLUE_FALLBACK_MS = 12'd200;
  localparam logic [11:0] CYAN_FALLBACK_MS = 12'd500;

  // Colours as {red, green, blue}
  localparam logic [23:0] COLOR_BLACK = 24'h000000;
  localparam logic [23:0] COLOR_RED   = 24'hFF0000;
  localparam logic [23:0] COLOR_BLUE  = 24'h000050;
  localparam logic [23:0] COLOR_CYAN  = 24'h2EFFB9;

  // Register reset values
  localparam logic [9:0]  RST_ALARM_TRIP_LEVEL = 10'd700;
  localparam logic [15:0] RST_FIRE_DURATION   = 16'd10000;
  localparam logic [15:0] RST_SETUP_DURATION  = 16'd10000;
  localparam logic [15:0] RST_RESET_DURATION  = 16'd2000;
  localparam logic [15:0] RST_CONNECT_DURATION = 16'd5000;
  localparam logic [15:0] RST_DISCONNECT_DURATION = 16'd5000;
  localparam logic [11:0] RST_BLINK_HALF_PERIOD = 12'd500;

  typedef struct packed {
    logic [9:0]  alarm_trip_level;
    logic [15:0] fire_duration_ms;
    logic [15:0] setup_duration_ms;
    logic [15:0] reset_duration_ms;
    logic [15:0] connect_duration_ms;
    logic [15:0] disconnect_duration_ms;
    logic [11:0] blink_half_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  link_state;
    logic        wifi_up;
    logic [9:0]  alarm_level;
    logic        manual_on;
  } item_t;

  typedef struct packed {
    logic        strip_write;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        rainbow_override;
    logic [1:0]  anim_code;
  } result_t;

  typedef struct packed {
    logic        prev_wifi;
    logic        prev_alarm_high;
    logic [2:0]  prev_link;
    logic        anim_active;
    anim_kind_t  anim_kind;
    logic [31:0] anim_start;
    logic [15:0] anim_length;
    logic        blink_enable;
    logic [11:0] blink_step;
    logic [31:0] blink_last;
    logic        blink_phase;
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sles_in_if.sv
// Input channel of the status LED event sequencer: one update tick per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sles_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [2:0]  link_state;
  logic        wifi_up;
  logic [9:0]  alarm_level;
  logic        manual_on;

  modport source (
    output valid, now_ms, link_state, wifi_up, alarm_level, manual_on,
    input  ready
  );
  modport sink (
    input  valid, now_ms, link_state, wifi_up, alarm_level, manual_on,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sles_out_if.sv
// Result channel of the status LED event sequencer: one strip frame per transaction.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sles_out_if;
  logic       valid;
  logic       ready;
  logic       strip_write;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       rainbow_override;
  logic [1:0] anim_code;

  modport source (
    output valid, strip_write, red, green, blue, rainbow_override, anim_code,
    input  ready
  );
  modport sink (
    input  valid, strip_write, red, green, blue, rainbow_override, anim_code,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/sles_cfg_if.sv
// Configuration write channel of the status LED event sequencer.
// Depends on sles_pkg for the address and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface sles_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [sles_pkg::CFG_ADDR_W-1:0]     addr;
  logic [sles_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> rtl/sles_step.sv
// Per-tick logic of the status LED event sequencer: edge detection, animation
// start and end, shared blinker. Purely combinational; depends on sles_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sles_step (
  input  sles_pkg::cfg_t    cfg,
  input  sles_pkg::state_t  st,
  input  sles_pkg::item_t   item,
  output sles_pkg::state_t  st_next,
  output sles_pkg::result_t res
);

  logic        high;
  logic        ev_setup;
  logic        ev_reset;
  logic        ev_connect;
  logic        ev_alarm;
  logic        ev_disc;
  logic        start;
  logic [31:0] elapsed;
  logic [31:0] since_blink;
  logic        expired;
  logic        due;
  logic        do_blink;
  logic        known;
  logic [11:0] half;
  logic [23:0] colour;
  logic [23:0] wr_colour;
  logic        wr_flag;

  // Compare against the previous tick
  assign high       = item.alarm_level >= cfg.alarm_trip_level;
  assign ev_setup   = (st.prev_link == sles_pkg::LINK_UNKNOWN) &&
                      (item.link_state == sles_pkg::LINK_SETUP) && !high;
  assign ev_reset   = (item.link_state == sles_pkg::LINK_RESET) &&
                      (st.prev_link != sles_pkg::LINK_RESET) && !high;
  assign ev_connect = (st.prev_link != sles_pkg::LINK_RUNNING) &&
                      (item.link_state == sles_pkg::LINK_RUNNING) && item.wifi_up && !high;
  assign ev_alarm   = high && !st.prev_alarm_high;
  assign ev_disc    = !item.wifi_up && st.prev_wifi && !high;
  assign start      = ev_setup || ev_reset || ev_connect || ev_alarm || ev_disc;

  // Elapsed times, modulo 2^32; a fresh start never ends in its own tick
  assign elapsed     = item.now_ms - st.anim_start;
  assign since_blink = item.now_ms - st.blink_last;
  assign expired     = !start && (elapsed > {16'd0, st.anim_length});

  always_comb begin
    st_next   = st;
    wr_flag   = 1'b0;
    wr_colour = sles_pkg::COLOR_BLACK;
    do_blink  = 1'b0;
    known     = 1'b1;
    half      = sles_pkg::FIRE_HALF_MS;
    colour    = sles_pkg::COLOR_BLACK;
    due       = 1'b0;
    res       = '0;

    if (item.manual_on) begin
      // Override: only track wifi and alarm level
      st_next.prev_wifi       = item.wifi_up;
      st_next.prev_alarm_high = high;
      res.rainbow_override    = 1'b1;
      res.anim_code           = st.anim_active ? st.anim_kind : sles_pkg::KIND_NONE;
    end else begin
      // Start the winning animation; later events take priority
      if (ev_disc) begin
        st_next.anim_kind   = sles_pkg::KIND_LINK;
        st_next.anim_length = cfg.disconnect_duration_ms;
      end else if (ev_alarm) begin
        st_next.anim_kind   = sles_pkg::KIND_ALARM;
        st_next.anim_length = cfg.fire_duration_ms;
      end else if (ev_connect) begin
        st_next.anim_kind   = sles_pkg::KIND_CONNECT;
        st_next.anim_length = cfg.connect_duration_ms;
      end else if (ev_reset) begin
        st_next.anim_kind   = sles_pkg::KIND_LINK;
        st_next.anim_length = cfg.reset_duration_ms;
      end else if (ev_setup) begin
        st_next.anim_kind   = sles_pkg::KIND_LINK;
        st_next.anim_length = cfg.setup_duration_ms;
      end
      if (start) begin
        st_next.anim_start  = item.now_ms;
        st_next.anim_active = 1'b1;
      end
      if (ev_setup || ev_reset || ev_connect || ev_disc) begin
        st_next.blink_enable = 1'b1;
        st_next.blink_step   = cfg.blink_half_period_ms;
      end

      if (st_next.anim_active) begin
        // Pick the frame source for the active animation
        unique case (st_next.anim_kind)
          sles_pkg::KIND_ALARM: begin
            do_blink = 1'b1;
            half     = sles_pkg::FIRE_HALF_MS;
            colour   = sles_pkg::COLOR_RED;
          end
          sles_pkg::KIND_LINK: begin
            half   = (st_next.blink_step != 12'd0) ? st_next.blink_step
                                                  : sles_pkg::BLUE_FALLBACK_MS;
            colour = sles_pkg::COLOR_BLUE;
            if (st_next.blink_enable) begin
              do_blink = 1'b1;
            end else begin
              wr_flag   = 1'b1;
              wr_colour = sles_pkg::COLOR_BLUE;
            end
          end
          sles_pkg::KIND_CONNECT: begin
            do_blink = 1'b1;
            half     = (st_next.blink_step != 12'd0) ? st_next.blink_step
                                                    : sles_pkg::CYAN_FALLBACK_MS;
            colour   = sles_pkg::COLOR_CYAN;
          end
          default: begin
            known = 1'b0;
          end
        endcase

        // Toggle the shared blinker once its half period has passed
        due = since_blink >= {20'd0, half};
        if (do_blink && due) begin
          st_next.blink_last  = item.now_ms;
          st_next.blink_phase = ~st.blink_phase;
          wr_flag   = 1'b1;
          wr_colour = st.blink_phase ? sles_pkg::COLOR_BLACK : colour;
        end

        // End the animation and blank the strip
        if (known && expired) begin
          st_next.anim_active = 1'b0;
          wr_flag   = 1'b1;
          wr_colour = sles_pkg::COLOR_BLACK;
        end
      end else begin
        wr_flag   = 1'b1;
        wr_colour = sles_pkg::COLOR_BLACK;
      end

      st_next.prev_wifi       = item.wifi_up;
      st_next.prev_alarm_high = high;
      st_next.prev_link       = item.link_state;

      res.strip_write = wr_flag;
      res.red         = wr_colour[23:16];
      res.green       = wr_colour[15:8];
      res.blue        = wr_colour[7:0];
      res.anim_code   = st_next.anim_active ? st_next.anim_kind : sles_pkg::KIND_NONE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/status_led_event_sequencer.sv
// Top level of the status LED event sequencer: input register, tick logic,
// result register, configuration registers. Depends on sles_pkg, the three
// channel interfaces and sles_step.
`timescale 1ns / 1ps
`default_nettype none

// Each tick transaction yields exactly one result transaction. A tick can be
// taken every clock cycle while the result channel keeps up. An accepted tick
// waits in the input register and moves into the result register once that
// register is free or being emptied, and its result is presented from there. The
// sequencer state updates in the same cycle a tick moves from the input register
// into the result register, so the state loop (two 32-bit subtract-and-compare
// paths plus selection) sets the rate at one tick per cycle when results are not
// stalled. Ticks keep flowing while a result waits, until both registers hold an
// item. Configuration writes are always taken and should be issued only while no
// tick is in flight. There is no memory and no clearing pass after reset.
module status_led_event_sequencer (
  input  wire             clk,
  input  wire             rst,
  sles_in_if.sink         items,
  sles_out_if.source      results,
  sles_cfg_if.sink        cfg
);

  sles_pkg::cfg_t    cfg_regs;
  sles_pkg::state_t  st;
  sles_pkg::state_t  st_next;
  sles_pkg::item_t   item;
  sles_pkg::result_t res_next;
  sles_pkg::result_t res;
  logic              item_vld;
  logic              res_vld;
  logic              advance;

  // Move the held tick forward when the result register is free
  assign advance     = item_vld && (!res_vld || results.ready);
  assign items.ready = !item_vld || advance;
  assign cfg.ready   = 1'b1;

  // Capture incoming tick transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (items.ready) begin
      item_vld <= items.valid;
    end
    if (items.valid && items.ready) begin
      item.now_ms      <= items.now_ms;
      item.link_state  <= items.link_state;
      item.wifi_up     <= items.wifi_up;
      item.alarm_level <= items.alarm_level;
      item.manual_on   <= items.manual_on;
    end
  end

  sles_step u_step (
    .cfg     (cfg_regs),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (res_next)
  );

  // Hold sequencer state; advance it once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (results.ready) begin
      res_vld <= 1'b0;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign results.valid            = res_vld;
  assign results.strip_write      = res.strip_write;
  assign results.red              = res.red;
  assign results.green            = res.green;
  assign results.blue             = res.blue;
  assign results.rainbow_override = res.rainbow_override;
  assign results.anim_code        = res.anim_code;

  // Configuration registers; writes to unused indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.alarm_trip_level       <= sles_pkg::RST_ALARM_TRIP_LEVEL;
      cfg_regs.fire_duration_ms       <= sles_pkg::RST_FIRE_DURATION;
      cfg_regs.setup_duration_ms      <= sles_pkg::RST_SETUP_DURATION;
      cfg_regs.reset_duration_ms      <= sles_pkg::RST_RESET_DURATION;
      cfg_regs.connect_duration_ms    <= sles_pkg::RST_CONNECT_DURATION;
      cfg_regs.disconnect_duration_ms <= sles_pkg::RST_DISCONNECT_DURATION;
      cfg_regs.blink_half_period_ms   <= sles_pkg::RST_BLINK_HALF_PERIOD;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        sles_pkg::REG_ALARM_TRIP_LEVEL:    cfg_regs.alarm_trip_level <= cfg.data[9:0];
        sles_pkg::REG_FIRE_DURATION:       cfg_regs.fire_duration_ms <= cfg.data;
        sles_pkg::REG_SETUP_DURATION:      cfg_regs.setup_duration_ms <= cfg.data;
        sles_pkg::REG_RESET_DURATION:      cfg_regs.reset_duration_ms <= cfg.data;
        sles_pkg::REG_CONNECT_DURATION:    cfg_regs.connect_duration_ms <= cfg.data;
        sles_pkg::REG_DISCONNECT_DURATION: cfg_regs.disconnect_duration_ms <= cfg.data;
        sles_pkg::REG_BLINK_HALF_PERIOD:   cfg_regs.blink_half_period_ms <= cfg.data[11:0];
        default: begin
        end
      endcase
    end
  end

  // A non-override tick that leaves no animation running blanks the strip
  a_idle_writes_black: assert property (@(posedge clk) disable iff (rst)
    (advance && !item.manual_on && !st_next.anim_active) |=>
      (res.strip_write && res.red == 8'd0 && res.green == 8'd0 && res.blue == 8'd0))
    else $error("idle tick did not blank the strip");

  // Override ticks never write the strip
  a_manual_no_write: assert property (@(posedge clk) disable iff (rst)
    (advance && item.manual_on) |=> (!res.strip_write && res.rainbow_override))
    else $error("override tick wrote the strip");

  // An active animation always has a real kind
  a_active_has_kind: assert property (@(posedge clk) disable iff (rst)
    st.anim_active |-> (st.anim_kind != sles_pkg::KIND_NONE))
    else $error("active animation without a kind");

  // A lit frame comes only from an animation still running
  a_lit_means_active: assert property (@(posedge clk) disable iff (rst)
    (res_vld && (res.red != 8'd0 || res.green != 8'd0 || res.blue != 8'd0)) |->
      (res.anim_code != sles_pkg::KIND_NONE))
    else $error("lit frame with no running animation");

  // State moves only with a tick
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(st.prev_link) && $stable(st.anim_active) &&
                  $stable(st.blink_last) && $stable(st.blink_phase)))
    else $error("state changed without a tick");

endmodule

`default_nettype wire

>>> verif/sles_checker.sv
// Scoreboard for the status LED event sequencer: watches the tick, frame and
// register channels, predicts every frame and compares it. Depends on sles_pkg
// and the three channel interfaces.
`timescale 1ns / 1ps

module sles_checker (
  input  logic clk,
  input  logic rst,
  sles_in_if   items,
  sles_out_if  results,
  sles_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  sles_pkg::cfg_t    regs;
  sles_pkg::state_t  seq;
  sles_pkg::result_t drawn;
  sles_pkg::result_t frames_due[$];
  int                frame_no;

  initial begin
    errors   = 0;
    pending  = 0;
    frame_no = 0;
  end

  // Print one line and count it
  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("frame %0d %s: got %0h, want %0h", frame_no, name, got, want));
    end
  endtask

  // Write one colour into the frame being predicted
  function automatic void paint(input logic [23:0] rgb);
    drawn.strip_write = 1'b1;
    {drawn.red, drawn.green, drawn.blue} = rgb;
  endfunction

  // Toggle the shared blinker once the half period has run out
  function automatic void blink(input logic [31:0] now, input logic [23:0] rgb,
                                input logic [11:0] half);
    if (now - seq.blink_last >= {20'd0, half}) begin
      seq.blink_last  = now;
      seq.blink_phase = ~seq.blink_phase;
      paint(seq.blink_phase ? rgb : sles_pkg::COLOR_BLACK);
    end
  endfunction

  function automatic void launch(input sles_pkg::anim_kind_t kind, input logic [31:0] now,
                                 input logic [15:0] len, input logic with_blink);
    seq.anim_kind   = kind;
    seq.anim_start  = now;
    seq.anim_length = len;
    seq.anim_active = 1'b1;
    if (with_blink) begin
      seq.blink_enable = 1'b1;
      seq.blink_step   = regs.blink_half_period_ms;
    end
  endfunction

  // Advance the sequencer by one tick and return the frame it writes
  function automatic sles_pkg::result_t predict_frame(input sles_pkg::item_t tick);
    logic        high;
    logic [31:0] elapsed;
    logic        drew_kind;
    drawn = '0;
    high  = tick.alarm_level >= regs.alarm_trip_level;
    if (tick.manual_on) begin
      seq.prev_wifi       = tick.wifi_up;
      seq.prev_alarm_high = high;
    end else begin
      // Later events in the tick override earlier ones
      if (seq.prev_link == sles_pkg::LINK_UNKNOWN && tick.link_state == sles_pkg::LINK_SETUP
          && !high)
        launch(sles_pkg::KIND_LINK, tick.now_ms, regs.setup_duration_ms, 1'b1);
      if (tick.link_state == sles_pkg::LINK_RESET && seq.prev_link != sles_pkg::LINK_RESET
          && !high)
        launch(sles_pkg::KIND_LINK, tick.now_ms, regs.reset_duration_ms, 1'b1);
      if (seq.prev_link != sles_pkg::LINK_RUNNING && tick.link_state == sles_pkg::LINK_RUNNING
          && tick.wifi_up && !high)
        launch(sles_pkg::KIND_CONNECT, tick.now_ms, regs.connect_duration_ms, 1'b1);
      if (high && !seq.prev_alarm_high)
        launch(sles_pkg::KIND_ALARM, tick.now_ms, regs.fire_duration_ms, 1'b0);
      if (!tick.wifi_up && seq.prev_wifi && !high)
        launch(sles_pkg::KIND_LINK, tick.now_ms, regs.disconnect_duration_ms, 1'b1);

      // Draw the running animation, then end it once its length is exceeded
      if (seq.anim_active) begin
        elapsed   = tick.now_ms - seq.anim_start;
        drew_kind = 1'b1;
        case (seq.anim_kind)
          sles_pkg::KIND_ALARM: blink(tick.now_ms, sles_pkg::COLOR_RED, sles_pkg::FIRE_HALF_MS);
          sles_pkg::KIND_LINK: begin
            if (seq.blink_enable)
              blink(tick.now_ms, sles_pkg::COLOR_BLUE,
                    (seq.blink_step != 12'd0) ? seq.blink_step : sles_pkg::BLUE_FALLBACK_MS);
            else
              paint(sles_pkg::COLOR_BLUE);
          end
          sles_pkg::KIND_CONNECT: blink(tick.now_ms, sles_pkg::COLOR_CYAN,
              (seq.blink_step != 12'd0) ? seq.blink_step : sles_pkg::CYAN_FALLBACK_MS);
          default: drew_kind = 1'b0;
        endcase
        if (drew_kind && elapsed > {16'd0, seq.anim_length}) begin
          seq.anim_active = 1'b0;
          paint(sles_pkg::COLOR_BLACK);
        end
      end else begin
        paint(sles_pkg::COLOR_BLACK);
      end

      seq.prev_wifi       = tick.wifi_up;
      seq.prev_alarm_high = high;
      seq.prev_link       = tick.link_state;
    end
    drawn.rainbow_override = tick.manual_on;
    drawn.anim_code        = seq.anim_active ? seq.anim_kind : sles_pkg::KIND_NONE;
    return drawn;
  endfunction

  always @(posedge clk) begin : monitor
    sles_pkg::item_t   tick;
    sles_pkg::result_t want;
    if (rst) begin
      regs = '{sles_pkg::RST_ALARM_TRIP_LEVEL, sles_pkg::RST_FIRE_DURATION,
               sles_pkg::RST_SETUP_DURATION, sles_pkg::RST_RESET_DURATION,
               sles_pkg::RST_CONNECT_DURATION, sles_pkg::RST_DISCONNECT_DURATION,
               sles_pkg::RST_BLINK_HALF_PERIOD};
      seq  = '0;
      frames_due.delete();
    end else begin
      // Compare each frame transaction with the oldest prediction
      if (results.valid && results.ready) begin
        if (frames_due.size() == 0) begin
          report($sformatf("frame %0d arrived with no tick outstanding", frame_no));
        end else begin
          want = frames_due.pop_front();
          check_field("strip_write", results.strip_write, want.strip_write);
          check_field("red", results.red, want.red);
          check_field("green", results.green, want.green);
          check_field("blue", results.blue, want.blue);
          check_field("rainbow_override", results.rainbow_override, want.rainbow_override);
          check_field("anim_code", results.anim_code, want.anim_code);
        end
        frame_no++;
      end

      // Track register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          sles_pkg::REG_ALARM_TRIP_LEVEL:    regs.alarm_trip_level     = cfg.data[9:0];
          sles_pkg::REG_FIRE_DURATION:       regs.fire_duration_ms     = cfg.data;
          sles_pkg::REG_SETUP_DURATION:      regs.setup_duration_ms    = cfg.data;
          sles_pkg::REG_RESET_DURATION:      regs.reset_duration_ms    = cfg.data;
          sles_pkg::REG_CONNECT_DURATION:    regs.connect_duration_ms  = cfg.data;
          sles_pkg::REG_DISCONNECT_DURATION: regs.disconnect_duration_ms = cfg.data;
          sles_pkg::REG_BLINK_HALF_PERIOD:   regs.blink_half_period_ms = cfg.data[11:0];
          default: ;
        endcase
      end

      // Predict the frame of each accepted tick
      if (items.valid && items.ready) begin
        tick.now_ms      = items.now_ms;
        tick.link_state  = items.link_state;
        tick.wifi_up     = items.wifi_up;
        tick.alarm_level = items.alarm_level;
        tick.manual_on   = items.manual_on;
        frames_due.push_back(predict_frame(tick));
      end
    end
    pending <= frames_due.size();
  end

endmodule

>>> verif/testbench.sv
// Top of the status LED event sequencer testbench: clock, reset, tick and register
// stimulus, frame back-pressure and the verdict. Depends on sles_pkg, the channel
// interfaces, status_led_event_sequencer and sles_checker.
`timescale 1ns / 1ps

module testbench;

  logic clk;
  logic rst;
  int   errors;
  int   pending;

  logic [31:0] clock_ms;
  logic [2:0]  cur_link;
  logic        cur_wifi;
  logic        alarm_on;
  int          burst_left;

  sles_in_if  items_ch ();
  sles_out_if results_ch ();
  sles_cfg_if cfg_ch ();

  status_led_event_sequencer uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  sles_checker scoreboard (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #4_000_000;
    $display("status_led_event_sequencer: mismatch");
    $finish;
  end

  // Stall the frame channel in modes that change every so often
  initial begin
    int mode;
    int span;
    int beat;
    results_ch.ready <= 1'b0;
    span = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
      end
      span--;
      beat++;
      case (mode)
        0:       results_ch.ready <= 1'b1;
        1:       results_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       results_ch.ready <= ($urandom_range(0, 3) == 0);
        default: results_ch.ready <= (beat % 5 == 0);
      endcase
    end
  end

  // Send one tick transaction, in bursts separated by random gaps
  task automatic send_tick(input logic [31:0] now, input logic [2:0] link, input logic wifi,
                           input logic [9:0] level, input logic manual);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    items_ch.valid       <= 1'b1;
    items_ch.now_ms      <= now;
    items_ch.link_state  <= link;
    items_ch.wifi_up     <= wifi;
    items_ch.alarm_level <= level;
    items_ch.manual_on   <= manual;
    do @(posedge clk); while (!items_ch.ready);
    burst_left--;
  endtask

  // Hold ticks back until every frame is in and the pipeline is empty
  task automatic drain();
    items_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register, keeping the write channel busy across the sequence
  task automatic program_registers(input sles_pkg::cfg_t s);
    sles_pkg::reg_index_t idx;
    idx = idx.first();
    cfg_ch.valid <= 1'b1;
    repeat (idx.num()) begin
      cfg_ch.addr <= idx;
      case (idx)
        sles_pkg::REG_ALARM_TRIP_LEVEL:    cfg_ch.data <= 16'(s.alarm_trip_level);
        sles_pkg::REG_FIRE_DURATION:       cfg_ch.data <= s.fire_duration_ms;
        sles_pkg::REG_SETUP_DURATION:      cfg_ch.data <= s.setup_duration_ms;
        sles_pkg::REG_RESET_DURATION:      cfg_ch.data <= s.reset_duration_ms;
        sles_pkg::REG_CONNECT_DURATION:    cfg_ch.data <= s.connect_duration_ms;
        sles_pkg::REG_DISCONNECT_DURATION: cfg_ch.data <= s.disconnect_duration_ms;
        default:                           cfg_ch.data <= 16'(s.blink_half_period_ms);
      endcase
      do @(posedge clk); while (!cfg_ch.ready);
      idx = idx.next();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic sles_pkg::cfg_t random_settings();
    sles_pkg::cfg_t s;
    s.alarm_trip_level       = 10'($urandom_range(0, 1023));
    s.fire_duration_ms       = 16'($urandom_range(0, 4000));
    s.setup_duration_ms      = 16'($urandom_range(0, 4000));
    s.reset_duration_ms      = 16'($urandom_range(0, 4000));
    s.connect_duration_ms    = 16'($urandom_range(0, 4000));
    s.disconnect_duration_ms = 16'($urandom_range(0, 4000));
    s.blink_half_period_ms   = ($urandom_range(0, 3) == 0) ? 12'd0 : 12'($urandom_range(1, 700));
    return s;
  endfunction

  // Random walk of link, Wi-Fi and alarm with mostly short time steps
  task automatic run_phase(input int count);
    int         roll;
    logic [9:0] level;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      clock_ms += $urandom_range(0, 150);
      else if (roll < 90) clock_ms += $urandom_range(150, 1200);
      else if (roll < 98) clock_ms += $urandom_range(1200, 20000);
      else                clock_ms = $urandom;
      if ($urandom_range(0, 99) < 12) begin
        if ($urandom_range(0, 99) < 85)
          cur_link = 3'($urandom_range(sles_pkg::LINK_UNKNOWN, sles_pkg::LINK_RUNNING));
        else
          cur_link = 3'($urandom_range(sles_pkg::LINK_RUNNING + 1, 7));
        if (cur_link == sles_pkg::LINK_RUNNING && $urandom_range(0, 3) != 0) cur_wifi = 1'b1;
      end
      if ($urandom_range(0, 99) < 8) cur_wifi = ~cur_wifi;
      if ($urandom_range(0, 99) < 6) alarm_on = ~alarm_on;
      roll = $urandom_range(0, 99);
      if (roll < 5)      level = 10'($urandom_range(0, 1023));
      else if (alarm_on) level = 10'($urandom_range(650, 1023));
      else               level = 10'($urandom_range(0, 720));
      send_tick(clock_ms, cur_link, cur_wifi, level, $urandom_range(0, 99) < 4);
    end
  endtask

  initial begin
    sles_pkg::cfg_t s;
    rst                  <= 1'b1;
    items_ch.valid       <= 1'b0;
    items_ch.now_ms      <= '0;
    items_ch.link_state  <= sles_pkg::LINK_UNKNOWN;
    items_ch.wifi_up     <= 1'b0;
    items_ch.alarm_level <= '0;
    items_ch.manual_on   <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.addr          <= sles_pkg::REG_ALARM_TRIP_LEVEL;
    cfg_ch.data          <= '0;
    burst_left = 0;
    cur_link   = sles_pkg::LINK_UNKNOWN;
    cur_wifi   = 1'b0;
    alarm_on   = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks with the reset settings
    send_tick(32'd0,     sles_pkg::LINK_UNKNOWN, 1'b0, 10'd0,    1'b0); // idle black
    send_tick(32'd10,    sles_pkg::LINK_SETUP,   1'b0, 10'd0,    1'b0); // first setup
    send_tick(32'd600,   sles_pkg::LINK_SETUP,   1'b0, 10'd0,    1'b0); // blink on
    send_tick(32'd1200,  sles_pkg::LINK_RESET,   1'b0, 10'd0,    1'b0); // credential reset
    send_tick(32'd1800,  sles_pkg::LINK_RUNNING, 1'b1, 10'd0,    1'b0); // connect
    send_tick(32'd2400,  sles_pkg::LINK_RUNNING, 1'b0, 10'd0,    1'b0); // Wi-Fi lost
    send_tick(32'd2500,  sles_pkg::LINK_RUNNING, 1'b1, 10'd1000, 1'b0); // alarm rise
    send_tick(32'd3100,  sles_pkg::LINK_RUNNING, 1'b1, 10'd1023, 1'b0); // at full scale
    send_tick(32'd3200,  sles_pkg::LINK_UNKNOWN, 1'b1, 10'd0,    1'b0); // alarm falls
    send_tick(32'd3300,  sles_pkg::LINK_SETUP,   1'b0, 10'd0,    1'b0); // setup and loss
    send_tick(32'd3400,  sles_pkg::LINK_RUNNING, 1'b1, 10'd0,    1'b0);
    send_tick(32'd3500,  sles_pkg::LINK_RESET,   1'b0, 10'd699,  1'b0); // reset and loss
    send_tick(32'd3600,  sles_pkg::LINK_UNKNOWN, 1'b0, 10'd700,  1'b0); // alarm at threshold
    send_tick(32'd3700,  sles_pkg::LINK_SETUP,   1'b1, 10'd800,  1'b1); // manual keeps link
    send_tick(32'd3800,  sles_pkg::LINK_SETUP,   1'b1, 10'd0,    1'b0); // setup after manual
    send_tick(32'd30000, sles_pkg::LINK_SETUP,   1'b1, 10'd0,    1'b0); // animation runs out
    send_tick(32'd30100, 3'd5,                   1'b1, 10'd0,    1'b0); // other link codes
    send_tick(32'd30200, 3'd7,                   1'b0, 10'd0,    1'b0);
    send_tick(32'd60000, 3'd4,                   1'b0, 10'd0,    1'b0);
    send_tick(32'hFFFF_FF00, sles_pkg::LINK_RESET, 1'b0, 10'd0,  1'b0); // near the time wrap
    send_tick(32'hFFFF_FFFF, sles_pkg::LINK_RESET, 1'b0, 10'd0,  1'b0);
    send_tick(32'h0000_0100, sles_pkg::LINK_RESET, 1'b0, 10'd0,  1'b0); // across the wrap
    send_tick(32'h0000_0300, 3'd6,                 1'b1, 10'd1023, 1'b1);
    send_tick(32'h0000_0400, sles_pkg::LINK_RUNNING, 1'b1, 10'd0, 1'b0);
    clock_ms = 32'h0000_0400;
    cur_link = sles_pkg::LINK_RUNNING;
    cur_wifi = 1'b1;

    run_phase(300);

    // Short animations at the default threshold
    drain();
    s = random_settings();
    s.alarm_trip_level = sles_pkg::RST_ALARM_TRIP_LEVEL;
    program_registers(s);
    run_phase(400);

    // Everything zero: alarm always high, fallback blink rates
    drain();
    program_registers('0);
    run_phase(250);

    // Every duration and the blink half period at its largest, threshold at 1000
    drain();
    program_registers('{10'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF});
    run_phase(250);

    // Threshold at the top of the field, fallback blink rates
    drain();
    s = random_settings();
    s.alarm_trip_level     = 10'd1023;
    s.blink_half_period_ms = 12'd0;
    program_registers(s);
    run_phase(250);

    repeat (2) begin
      drain();
      program_registers(random_settings());
      run_phase(275);
    end

    drain();
    if (errors == 0) begin
      $display("status_led_event_sequencer: match");
    end else begin
      $display("status_led_event_sequencer: mismatch");
    end
    $finish;
  end

endmodule
